// ===== rtl/cpbb_pkg.sv =====
`default_nettype none
package cpbb_pkg;

  localparam int CRD_W   = 32;
  localparam int EPS_W   = 16;
  localparam int A_W     = 35;
  localparam int H_W     = 34;
  localparam int C_W     = 33;
  localparam int NUM_W   = 37;
  localparam int DEN_W   = 36;
  localparam int MAG_W   = 36;
  localparam int MUL_W   = 36;
  localparam int HALF_W  = 18;
  localparam int PROD_W  = 72;
  localparam int D_W     = 68;
  localparam int SQ_IN_W = 70;
  localparam int ROOT_W  = 35;
  localparam int WIDE_W  = 38;

  localparam logic [1:0] CMD_MOVE  = 2'd0;
  localparam logic [1:0] CMD_LINE  = 2'd1;
  localparam logic [1:0] CMD_CURVE = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_CHK,
    ST_MHH,
    ST_MAC,
    ST_SQRT,
    ST_TRY,
    ST_DIV,
    ST_LMUL,
    ST_LWAIT,
    ST_NEXT,
    ST_DONE
  } cpbb_state_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] min_x;
    logic signed [CRD_W-1:0] min_y;
    logic signed [CRD_W-1:0] max_x;
    logic signed [CRD_W-1:0] max_y;
  } box_t;

  function automatic box_t add_pt(box_t b, logic signed [CRD_W-1:0] x,
                                  logic signed [CRD_W-1:0] y);
    box_t r;
    r = b;
    if (x < b.min_x) r.min_x = x;
    if (x > b.max_x) r.max_x = x;
    if (y < b.min_y) r.min_y = y;
    if (y > b.max_y) r.max_y = y;
    return r;
  endfunction

  function automatic logic [WIDE_W-1:0] mag_w(logic signed [WIDE_W-1:0] v);
    return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpbb_mul.sv =====
`default_nettype none
module cpbb_mul (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [cpbb_pkg::MUL_W-1:0]  op_a,
  input  wire [cpbb_pkg::MUL_W-1:0]  op_b,
  output logic                       done,
  output logic [cpbb_pkg::PROD_W-1:0] prod
);
  import cpbb_pkg::*;

  // Four 18x18 partial products, one per cycle, summed into the accumulator.
  logic [MUL_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [HALF_W-1:0] pa, pb;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0] pp_sh;

  always_comb begin
    pa = cnt_r[0] ? a_r[MUL_W-1:HALF_W] : a_r[HALF_W-1:0];
    pb = cnt_r[1] ? b_r[MUL_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp = pa * pb;
    pp_sh = PROD_W'(pp) << (HALF_W * (32'(cnt_r[0]) + 32'(cnt_r[1])));
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = op_a;
      b_nxt = op_b;
      acc_nxt = '0;
      cnt_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ===== rtl/cpbb_sqrt.sv =====
`default_nettype none
module cpbb_sqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [cpbb_pkg::SQ_IN_W-1:0]  rad,
  output logic                         done,
  output logic [cpbb_pkg::ROOT_W-1:0]  root
);
  import cpbb_pkg::*;

  localparam int REM_W = 40;

  // Digit-by-digit square root, one result bit per cycle.
  logic [SQ_IN_W-1:0] d_r, d_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], d_r[SQ_IN_W-1:SQ_IN_W-2]};
    trial = {REM_W'(root_r), 2'b01} [REM_W-1:0];
    d_nxt = d_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt = rad;
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = 6'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      d_nxt = {d_r[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== rtl/cpbb_div.sv =====
`default_nettype none
module cpbb_div #(
  parameter int QW = 29
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [cpbb_pkg::MAG_W-1:0]  num,
  input  wire [cpbb_pkg::MAG_W-1:0]  den,
  output logic                       done,
  output logic [QW-1:0]              quo
);
  import cpbb_pkg::*;

  localparam int REM_W = MAG_W + 2;
  localparam int CW    = $clog2(QW + 1);

  // Restoring division of num * 2^(QW-1) by den, with num <= den.
  logic [REM_W-1:0] rem_r, rem_nxt, rem_sub;
  logic [MAG_W-1:0] den_r, den_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    ge = rem_r >= REM_W'(den_r);
    rem_sub = ge ? rem_r - REM_W'(den_r) : rem_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = REM_W'(num);
      den_nxt = den;
      q_nxt = '0;
      cnt_nxt = CW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = {rem_sub[REM_W-2:0], 1'b0};
      q_nxt = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = q_r;
endmodule
`default_nettype wire

// ===== rtl/cubic_path_bounding_box_top.sv =====
`default_nettype none
// Running bounding box of a path built from move, line, cubic curve and close
// items, coordinates in signed fixed point with FRAC_BITS fraction bits. Each
// accepted item yields exactly one result item: the box after that item. Move,
// line and close go from acceptance straight to the result. A curve also
// finds, for x and then y, the parameter values where the derivative is zero
// and adds the curve point there; this runs on one shared multiplier, one
// bit-serial square root and one bit-serial divider, all under one sequencer.
// A curve has up to four interior extrema, each evaluated point costing 12
// multiplies. in_ready is high only while the sequencer is idle; a finished
// box waits in the output register, so the next item is accepted while the
// previous result is still unclaimed.
// cfg_we writes the near-zero threshold; write it only while the block is idle.
module cubic_path_bounding_box_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [1:0]                        in_cmd,
  input  wire                              in_new_path,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p1_x,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p1_y,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p2_x,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p2_y,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p3_x,
  input  wire signed [cpbb_pkg::CRD_W-1:0] in_p3_y,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [cpbb_pkg::CRD_W-1:0] out_box_min_x,
  output logic signed [cpbb_pkg::CRD_W-1:0] out_box_min_y,
  output logic signed [cpbb_pkg::CRD_W-1:0] out_box_max_x,
  output logic signed [cpbb_pkg::CRD_W-1:0] out_box_max_y,
  input  wire                              cfg_we,
  input  wire [cpbb_pkg::EPS_W-1:0]        cfg_wdata
);
  import cpbb_pkg::*;

  // Fraction bits of the curve parameter t, and the quotient width (t <= 1).
  localparam int TB = (FRAC_BITS + 12 > 28) ? 28 : FRAC_BITS + 12;
  localparam int QW = TB + 1;
  localparam logic [PROD_W-1:0] RND = (PROD_W'(1) << TB) - PROD_W'(1);

  cpbb_state_t state_r, state_nxt;

  logic [EPS_W-1:0]        eps_r;
  logic signed [CRD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CRD_W-1:0] sp_x_r, sp_x_nxt, sp_y_r, sp_y_nxt;
  box_t                    box_r, box_nxt, obox_r, obox_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Curve control points, index 0 is the start point.
  logic signed [CRD_W-1:0] cvx_r [4];
  logic signed [CRD_W-1:0] cvy_r [4];
  logic                    cv_load;

  logic                    axis_r, axis_nxt;
  logic                    second_r, second_nxt;
  logic signed [A_W-1:0]   a_r, a_nxt;
  logic signed [H_W-1:0]   h_r, h_nxt;
  logic signed [C_W-1:0]   c_r, c_nxt;
  logic [D_W-1:0]          sq_r, sq_nxt;
  logic [ROOT_W-1:0]       s_r, s_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic signed [DEN_W-1:0] den_r, den_nxt;
  logic [QW-1:0]           t_r, t_nxt;
  logic signed [CRD_W-1:0] w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  logic signed [CRD_W-1:0] ex_r, ex_nxt;
  logic                    ev_y_r, ev_y_nxt;
  logic [2:0]              k_r, k_nxt;

  logic                    mul_start, mul_done;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic                    sq_start, sq_done;
  logic [SQ_IN_W-1:0]      sq_in;
  logic [ROOT_W-1:0]       sq_root;
  logic                    div_start, div_done;
  logic [MAG_W-1:0]        div_n, div_d;
  logic [QW-1:0]           div_q;

  cpbb_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  cpbb_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .rad(sq_in),
    .done(sq_done), .root(sq_root)
  );

  cpbb_div #(.QW(QW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    logic signed [CRD_W-1:0]  fx, fy, lp, lq;
    logic signed [WIDE_W-1:0] q0, q1, q2, q3, aw, hw, cw, sw, tmp;
    logic [WIDE_W-1:0]        m3a, m6h, eps_w;
    logic [D_W:0]             ac_sum;
    logic                     bad;
    logic [MAG_W-1:0]         n_mag, d_mag;
    logic signed [C_W-1:0]    diff;
    logic [PROD_W-1:0]        pr;
    logic [H_W-1:0]           shv;
    logic signed [H_W:0]      res;
    box_t                     b;

    state_nxt = state_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    sp_x_nxt = sp_x_r;
    sp_y_nxt = sp_y_r;
    box_nxt = box_r;
    obox_nxt = obox_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cv_load = 1'b0;
    axis_nxt = axis_r;
    second_nxt = second_r;
    a_nxt = a_r;
    h_nxt = h_r;
    c_nxt = c_r;
    sq_nxt = sq_r;
    s_nxt = s_r;
    num_nxt = num_r;
    den_nxt = den_r;
    t_nxt = t_r;
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    w2_nxt = w2_r;
    w3_nxt = w3_r;
    ex_nxt = ex_r;
    ev_y_nxt = ev_y_r;
    k_nxt = k_r;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    sq_in = '0;
    div_start = 1'b0;

    // Control points and derivative coefficients for the selected axis.
    q0 = WIDE_W'(axis_r ? cvy_r[0] : cvx_r[0]);
    q1 = WIDE_W'(axis_r ? cvy_r[1] : cvx_r[1]);
    q2 = WIDE_W'(axis_r ? cvy_r[2] : cvx_r[2]);
    q3 = WIDE_W'(axis_r ? cvy_r[3] : cvx_r[3]);
    aw = WIDE_W'(a_r);
    hw = WIDE_W'(h_r);
    cw = WIDE_W'(c_r);
    sw = WIDE_W'({1'b0, s_r});
    m3a = mag_w(aw * 3);
    m6h = mag_w(hw * 6);
    eps_w = WIDE_W'(eps_r);
    ac_sum = (D_W + 1)'(sq_r) + (D_W + 1)'(mul_p[D_W-1:0]);

    // Root check: the root num/den must lie in [0,1].
    n_mag = num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
    d_mag = den_r[DEN_W-1] ? MAG_W'(-den_r) : MAG_W'(den_r);
    bad = (den_r == '0) || ((num_r != '0) && (num_r[NUM_W-1] != den_r[DEN_W-1])) ||
          (n_mag > d_mag);
    div_n = n_mag;
    div_d = d_mag;

    // One linear interpolation step of the de Casteljau evaluation.
    case (k_r)
      3'd1, 3'd4: begin
        lp = w1_r;
        lq = w2_r;
      end
      3'd2: begin
        lp = w2_r;
        lq = w3_r;
      end
      default: begin
        lp = w0_r;
        lq = w1_r;
      end
    endcase
    diff = C_W'(lq) - C_W'(lp);
    pr = mul_p + (diff[C_W-1] ? RND : '0);
    shv = H_W'(pr >> TB);
    res = (H_W + 1)'(lp) + (diff[C_W-1] ? -(H_W + 1)'(shv) : (H_W + 1)'(shv));

    fx = '0;
    fy = '0;
    b = box_r;
    tmp = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_MOVE, CMD_LINE: begin
              fx = in_p1_x;
              fy = in_p1_y;
            end
            CMD_CLOSE: begin
              fx = sp_x_r;
              fy = sp_y_r;
            end
            default: begin
              fx = cur_x_r;
              fy = cur_y_r;
            end
          endcase
          if (in_new_path) begin
            b.min_x = fx;
            b.max_x = fx;
            b.min_y = fy;
            b.max_y = fy;
          end
          b = add_pt(b, fx, fy);
          state_nxt = ST_DONE;
          case (in_cmd)
            CMD_MOVE: begin
              sp_x_nxt = in_p1_x;
              sp_y_nxt = in_p1_y;
              cur_x_nxt = in_p1_x;
              cur_y_nxt = in_p1_y;
            end
            CMD_CURVE: begin
              b = add_pt(b, in_p3_x, in_p3_y);
              cv_load = 1'b1;
              cur_x_nxt = in_p3_x;
              cur_y_nxt = in_p3_y;
              axis_nxt = 1'b0;
              state_nxt = ST_COEF;
            end
            default: begin
              cur_x_nxt = fx;
              cur_y_nxt = fy;
            end
          endcase
          box_nxt = b;
        end
      end

      ST_COEF: begin
        tmp = q3 - q0 + (q1 - q2) * 3;
        a_nxt = A_W'(tmp);
        tmp = q0 + q2 - q1 * 2;
        h_nxt = H_W'(tmp);
        tmp = q1 - q0;
        c_nxt = C_W'(tmp);
        second_nxt = 1'b0;
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (m3a <= eps_w) begin
          // Derivative is linear: one root at -C / 2H.
          if (m6h > eps_w) begin
            tmp = -cw;
            num_nxt = NUM_W'(tmp);
            tmp = hw * 2;
            den_nxt = DEN_W'(tmp);
            state_nxt = ST_TRY;
          end else begin
            state_nxt = ST_NEXT;
          end
        end else begin
          mul_start = 1'b1;
          mul_a = MUL_W'(mag_w(hw));
          mul_b = MUL_W'(mag_w(hw));
          state_nxt = ST_MHH;
        end
      end

      ST_MHH: begin
        if (mul_done) begin
          sq_nxt = mul_p[D_W-1:0];
          mul_start = 1'b1;
          mul_a = MUL_W'(mag_w(aw));
          mul_b = MUL_W'(mag_w(cw));
          state_nxt = ST_MAC;
        end
      end

      ST_MAC: begin
        if (mul_done) begin
          // Discriminant D = H*H - A*C, formed from magnitudes.
          if (a_r[A_W-1] != c_r[C_W-1]) begin
            sq_start = 1'b1;
            sq_in = SQ_IN_W'(ac_sum);
            state_nxt = ST_SQRT;
          end else if (mul_p[D_W-1:0] <= sq_r) begin
            sq_start = 1'b1;
            sq_in = SQ_IN_W'(sq_r - mul_p[D_W-1:0]);
            state_nxt = ST_SQRT;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end

      ST_SQRT: begin
        if (sq_done) begin
          s_nxt = sq_root;
          tmp = -hw - WIDE_W'({1'b0, sq_root});
          num_nxt = NUM_W'(tmp);
          den_nxt = DEN_W'(a_r);
          second_nxt = 1'b1;
          state_nxt = ST_TRY;
        end
      end

      ST_TRY: begin
        if (bad) begin
          state_nxt = ST_NEXT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          t_nxt = div_q;
          w0_nxt = cvx_r[0];
          w1_nxt = cvx_r[1];
          w2_nxt = cvx_r[2];
          w3_nxt = cvx_r[3];
          ev_y_nxt = 1'b0;
          k_nxt = 3'd0;
          state_nxt = ST_LMUL;
        end
      end

      ST_LMUL: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(diff[C_W-1] ? -diff : diff);
        mul_b = MUL_W'(t_r);
        state_nxt = ST_LWAIT;
      end

      ST_LWAIT: begin
        if (mul_done) begin
          state_nxt = ST_LMUL;
          k_nxt = k_r + 3'd1;
          case (k_r)
            3'd0, 3'd3: w0_nxt = CRD_W'(res);
            3'd1, 3'd4: w1_nxt = CRD_W'(res);
            3'd2: w2_nxt = CRD_W'(res);
            default: begin
              if (!ev_y_r) begin
                ex_nxt = CRD_W'(res);
                w0_nxt = cvy_r[0];
                w1_nxt = cvy_r[1];
                w2_nxt = cvy_r[2];
                w3_nxt = cvy_r[3];
                ev_y_nxt = 1'b1;
                k_nxt = 3'd0;
              end else begin
                box_nxt = add_pt(box_r, ex_r, CRD_W'(res));
                state_nxt = ST_NEXT;
              end
            end
          endcase
        end
      end

      ST_NEXT: begin
        if (second_r) begin
          second_nxt = 1'b0;
          tmp = sw - hw;
          num_nxt = NUM_W'(tmp);
          state_nxt = ST_TRY;
        end else if (!axis_r) begin
          axis_nxt = 1'b1;
          state_nxt = ST_COEF;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          obox_nxt = box_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    h_r <= h_nxt;
    c_r <= c_nxt;
    sq_r <= sq_nxt;
    s_r <= s_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    t_r <= t_nxt;
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
    w2_r <= w2_nxt;
    w3_r <= w3_nxt;
    ex_r <= ex_nxt;
    ev_y_r <= ev_y_nxt;
    k_r <= k_nxt;
    second_r <= second_nxt;
    axis_r <= axis_nxt;
    obox_r <= obox_nxt;
    if (cv_load) begin
      cvx_r[0] <= cur_x_r;
      cvy_r[0] <= cur_y_r;
      cvx_r[1] <= in_p1_x;
      cvy_r[1] <= in_p1_y;
      cvx_r[2] <= in_p2_x;
      cvy_r[2] <= in_p2_y;
      cvx_r[3] <= in_p3_x;
      cvy_r[3] <= in_p3_y;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eps_r <= EPS_W'(1);
      cur_x_r <= '0;
      cur_y_r <= '0;
      sp_x_r <= '0;
      sp_y_r <= '0;
      box_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      sp_x_r <= sp_x_nxt;
      sp_y_r <= sp_y_nxt;
      box_r <= box_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_box_min_x = obox_r.min_x;
  assign out_box_min_y = obox_r.min_y;
  assign out_box_max_x = obox_r.max_x;
  assign out_box_max_y = obox_r.max_y;
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpbb_pkg::*;

  // Clock, reset and the block's ports.
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic in_new_path;
  logic signed [CRD_W-1:0] in_p1_x, in_p1_y, in_p2_x, in_p2_y, in_p3_x, in_p3_y;
  logic out_valid;
  logic out_ready;
  logic signed [CRD_W-1:0] out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  cubic_path_bounding_box_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_new_path(in_new_path),
    .in_p1_x(in_p1_x), .in_p1_y(in_p1_y),
    .in_p2_x(in_p2_x), .in_p2_y(in_p2_y),
    .in_p3_x(in_p3_x), .in_p3_y(in_p3_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_box_min_x(out_box_min_x), .out_box_min_y(out_box_min_y),
    .out_box_max_x(out_box_max_x), .out_box_max_y(out_box_max_y),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  localparam int T_BITS = 28;  // min(FRAC_BITS + 12, 28) for 16 fraction bits

  // Shadow copy of the block's state, advanced once per accepted item.
  longint eps_shadow;
  longint pen_x, pen_y, start_x, start_y;
  longint bb_min_x, bb_min_y, bb_max_x, bb_max_y;
  longint ctl_x[4], ctl_y[4];

  // Boxes predicted for items that are accepted but not yet seen at the output.
  box_t pending_boxes[$];
  int   fail_count;

  // Flags that shape the traffic: a long receiver hold-off and a mode with no gaps.
  bit hold_request;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog allows several times the slowest run: every item a curve with
  // four interior extrema, plus long gaps on both sides.
  initial begin
    #(50_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------
  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic grow_box(longint x, longint y);
    if (x < bb_min_x) bb_min_x = x;
    if (x > bb_max_x) bb_max_x = x;
    if (y < bb_min_y) bb_min_y = y;
    if (y > bb_max_y) bb_max_y = y;
  endtask

  // The arithmetic right shift floors, which matches the block's rounding.
  function automatic longint blend(longint p, longint q, longint t);
    longint prod;
    prod = (q - p) * t;
    return p + (prod >>> T_BITS);
  endfunction

  function automatic longint curve_at(longint q[4], longint t);
    longint a, b, c;
    a = blend(q[0], q[1], t);
    b = blend(q[1], q[2], t);
    c = blend(q[2], q[3], t);
    return blend(blend(a, b, t), blend(b, c, t), t);
  endfunction

  // A root num/den is used only when it lies in [0,1].
  task automatic add_root_point(longint num, longint den);
    logic [127:0] n, d, t;
    if (den == 0) return;
    if (num != 0 && ((num < 0) != (den < 0))) return;
    n = mag64(num);
    d = mag64(den);
    if (n > d) return;
    t = (n << T_BITS) / d;
    grow_box(curve_at(ctl_x, longint'(t)), curve_at(ctl_y, longint'(t)));
  endtask

  task automatic add_extrema(longint q[4]);
    longint a, h, c, s;
    logic signed [135:0] a_w, h_w, c_w, disc;
    logic [127:0] root, cand;
    a = -q[0] + 3 * q[1] - 3 * q[2] + q[3];
    h = q[0] + q[2] - 2 * q[1];
    c = q[1] - q[0];
    // A vanishing quadratic term falls back to the linear solve.
    if (mag64(3 * a) <= eps_shadow) begin
      if (mag64(6 * h) > eps_shadow) add_root_point(-c, 2 * h);
      return;
    end
    a_w = a;
    h_w = h;
    c_w = c;
    disc = h_w * h_w - a_w * c_w;
    if (disc < 0) return;
    root = '0;
    for (int bit_i = 34; bit_i >= 0; bit_i--) begin
      cand = root | (128'd1 << bit_i);
      if (cand * cand <= 128'(disc)) root = cand;
    end
    s = longint'(root);
    add_root_point(-h - s, a);
    add_root_point(-h + s, a);
  endtask

  task automatic predict_box(logic [1:0] cmd, logic restart, longint x1, longint y1,
                             longint x2, longint y2, longint x3, longint y3);
    longint fx, fy;
    box_t b;
    case (cmd)
      CMD_MOVE, CMD_LINE: begin
        fx = x1;
        fy = y1;
      end
      CMD_CLOSE: begin
        fx = start_x;
        fy = start_y;
      end
      default: begin
        fx = pen_x;
        fy = pen_y;
      end
    endcase
    if (restart) begin
      bb_min_x = fx;
      bb_max_x = fx;
      bb_min_y = fy;
      bb_max_y = fy;
    end
    grow_box(fx, fy);
    if (cmd == CMD_MOVE) begin
      start_x = x1;
      start_y = y1;
      pen_x = x1;
      pen_y = y1;
    end else if (cmd == CMD_CURVE) begin
      ctl_x = '{pen_x, x1, x2, x3};
      ctl_y = '{pen_y, y1, y2, y3};
      grow_box(x3, y3);
      pen_x = x3;
      pen_y = y3;
      add_extrema(ctl_x);
      add_extrema(ctl_y);
    end else begin
      pen_x = fx;
      pen_y = fy;
    end
    b.min_x = bb_min_x[31:0];
    b.min_y = bb_min_y[31:0];
    b.max_x = bb_max_x[31:0];
    b.max_y = bb_max_y[31:0];
    pending_boxes.push_back(b);
  endtask

  // ------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------
  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called just after a falling edge. Inputs change only on falling edges, so
  // blocking assignments here cannot race the block's rising-edge logic.
  task automatic send_item(logic [1:0] cmd, logic restart, longint x1, longint y1,
                           longint x2, longint y2, longint x3, longint y3);
    int gap;
    in_cmd = cmd;
    in_new_path = restart;
    in_p1_x = x1[31:0];
    in_p1_y = y1[31:0];
    in_p2_x = x2[31:0];
    in_p2_y = y2[31:0];
    in_p3_x = x3[31:0];
    in_p3_y = y3[31:0];
    in_valid = 1'b1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_box(cmd, restart, x1, y1, x2, y2, x3, y3);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_and_set_eps(logic [EPS_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    // Every item yields a result, so once the queue is empty the block is idle.
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    eps_shadow = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Result side: random back-pressure, with one long hold-off on request.
  // ------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end else if (no_gaps) begin
        out_ready = 1'b1;
      end else begin
        out_ready = (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Each result item is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    box_t exp_box;
    if (rst_n && out_valid && out_ready) begin
      if (pending_boxes.size() == 0) begin
        $display("%0t: result item with no prediction waiting", $time);
        fail_count++;
      end else begin
        exp_box = pending_boxes.pop_front();
        if (out_box_min_x !== exp_box.min_x) begin
          $display("%0t: box_min_x expected %0d actual %0d", $time, exp_box.min_x,
                   out_box_min_x);
          fail_count++;
        end
        if (out_box_min_y !== exp_box.min_y) begin
          $display("%0t: box_min_y expected %0d actual %0d", $time, exp_box.min_y,
                   out_box_min_y);
          fail_count++;
        end
        if (out_box_max_x !== exp_box.max_x) begin
          $display("%0t: box_max_x expected %0d actual %0d", $time, exp_box.max_x,
                   out_box_max_x);
          fail_count++;
        end
        if (out_box_max_y !== exp_box.max_y) begin
          $display("%0t: box_max_y expected %0d actual %0d", $time, exp_box.max_y,
                   out_box_max_y);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  // Curves and lines before any move start from the reset point at the origin.
  task automatic test_start_from_reset();
    send_item(CMD_CURVE, 1'b0, 1000, -500, -2000, 3000, 400, 400);
    send_item(CMD_LINE, 1'b0, -70000, 90000, 0, 0, 0, 0);
    send_item(CMD_CLOSE, 1'b0, 5, 5, 5, 5, 5, 5);
  endtask

  // Field extremes, every command, and a fresh box on each kind of command.
  task automatic test_commands_and_extremes();
    send_item(CMD_MOVE, 1'b1, MAX32, MIN32, -1, -1, -1, -1);
    send_item(CMD_LINE, 1'b0, MIN32, MAX32, 0, 0, 0, 0);
    send_item(CMD_CLOSE, 1'b0, -1, -1, -1, -1, -1, -1);
    send_item(CMD_LINE, 1'b1, 12345, -54321, 0, 0, 0, 0);
    send_item(CMD_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CURVE, 1'b1, MAX32, MAX32, MIN32, MIN32, MAX32, MIN32);
    send_item(CMD_CURVE, 1'b0, MIN32, MAX32, MAX32, MIN32, MIN32, MAX32);
    send_item(CMD_MOVE, 1'b0, MIN32, MIN32, MAX32, MAX32, MAX32, MAX32);
    send_item(CMD_CURVE, 1'b0, MAX32, MAX32, MAX32, MAX32, MIN32, MIN32);
  endtask

  // Quadratic-like curves take the linear solve; a double root and a curve
  // with no real root go through the square root path.
  task automatic test_curve_cases();
    send_item(CMD_MOVE, 1'b1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CURVE, 1'b0, 100, 100, 100, 100, 0, 0);
    send_item(CMD_MOVE, 1'b0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CURVE, 1'b0, 10, 10, 20, 20, 30, 30);
    send_item(CMD_MOVE, 1'b0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CURVE, 1'b1, 0, 0, 0, 0, -900000, 900000);
    send_item(CMD_CURVE, 1'b0, -800000, 4000000, 3000000, -5000000, 700000, 10);
    send_item(CMD_CURVE, 1'b0, 700001, 11, 700003, 12, 700006, 14);
  endtask

  // The near-zero threshold decides between the two solves for small curves.
  task automatic test_eps_extremes();
    drain_and_set_eps(16'd0);
    send_item(CMD_MOVE, 1'b1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CURVE, 1'b0, 100, 100, 100, 100, 1, -1);
    send_item(CMD_CURVE, 1'b0, 300, -300, -250, 250, 1, 1);
    drain_and_set_eps(16'hFFFF);
    send_item(CMD_CURVE, 1'b1, 3000, -3000, -2500, 2500, 10, 10);
    send_item(CMD_CURVE, 1'b0, 30000, -30000, -25000, 25000, 4, 4);
  endtask

  function automatic longint rand_coord();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) return longint'($signed($urandom()));
    if (mode < 7) return longint'($signed($urandom_range(0, 2 * 1048576))) - 1048576;
    return longint'($urandom_range(0, 600)) - 300;
  endfunction

  // A curve end that nearly cancels the cubic term, so the near-zero test bites.
  function automatic longint flat_end(longint p0, longint p1, longint p2);
    longint e;
    e = p0 - 3 * p1 + 3 * p2 + longint'($urandom_range(0, 40000)) - 20000;
    if (e > MAX32 || e < MIN32) return rand_coord();
    return e;
  endfunction

  // Random paths: mostly well-formed subpaths (move, then lines and curves,
  // sometimes a close), with loose commands mixed in as noise.
  task automatic test_random_paths(int count);
    int sent, seg_len, kind;
    longint x1, y1, x2, y2, x3, y3;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(CMD_MOVE, $urandom_range(0, 2) == 0, rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
      seg_len = $urandom_range(1, 8);
      for (int k = 0; k < seg_len; k++) begin
        kind = $urandom_range(0, 9);
        x1 = rand_coord(); y1 = rand_coord();
        x2 = rand_coord(); y2 = rand_coord();
        x3 = rand_coord(); y3 = rand_coord();
        if (kind < 3) begin
          send_item(CMD_LINE, $urandom_range(0, 15) == 0, x1, y1, x2, y2, x3, y3);
        end else if (kind < 9) begin
          if ($urandom_range(0, 3) == 0) begin
            x3 = flat_end(pen_x, x1, x2);
            y3 = flat_end(pen_y, y1, y2);
          end
          send_item(CMD_CURVE, $urandom_range(0, 15) == 0, x1, y1, x2, y2, x3, y3);
        end else begin
          send_item(CMD_CLOSE, $urandom_range(0, 15) == 0, x1, y1, x2, y2, x3, y3);
        end
        sent++;
      end
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // output register fills and the block has to hold off its input.
  task automatic test_output_stall();
    @(negedge clk);
    hold_request = 1'b1;
    for (int k = 0; k < 6; k++)
      send_item(CMD_LINE, 1'b0, rand_coord(), rand_coord(), 0, 0, 0, 0);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_MOVE;
    in_new_path = 1'b0;
    in_p1_x = '0; in_p1_y = '0; in_p2_x = '0; in_p2_y = '0; in_p3_x = '0; in_p3_y = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_request = 1'b0;
    no_gaps = 1'b0;
    fail_count = 0;
    eps_shadow = 1;
    pen_x = 0; pen_y = 0; start_x = 0; start_y = 0;
    bb_min_x = 0; bb_min_y = 0; bb_max_x = 0; bb_max_y = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_start_from_reset();
    test_commands_and_extremes();
    test_curve_cases();
    test_eps_extremes();

    // The random part runs under four thresholds, the reset value first.
    drain_and_set_eps(16'd1);
    test_random_paths(300);
    test_output_stall();
    drain_and_set_eps(16'd0);
    no_gaps = 1'b1;
    test_random_paths(300);
    no_gaps = 1'b0;
    drain_and_set_eps(16'hFFFF);
    test_random_paths(300);
    drain_and_set_eps(16'($urandom_range(2, 65534)));
    test_random_paths(300);

    in_valid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
